// ===== src/mcsr_pkg.sv =====
// Shared types, codes and helpers for the mirror copy select and repair block.
package mcsr_pkg;

   localparam int NUM_COPIES = 8;
   localparam logic [3:0] COPY_MAX = 4'd8;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_IO = 3'd1;
   localparam logic [2:0] ST_NODEV = 3'd3;
   localparam logic [2:0] ST_STALE = 3'd4;

   localparam logic [1:0] REG_CHILD_COUNT = 2'd0;
   localparam logic [1:0] REG_REPLACING = 2'd1;
   localparam logic [1:0] REG_OFFSET_SHIFT = 2'd2;
   localparam logic [1:0] REG_REPAIR_ALLOWED = 2'd3;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_REPAIR = 2'd2,
      KIND_COMPLETE = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_MOD,
      ENG_DISPATCH,
      ENG_ISSUE_ALL,
      ENG_SEL1,
      ENG_SEL2,
      ENG_FIN_SCAN,
      ENG_FIN_DECIDE,
      ENG_REPAIR
   } eng_state_type;

   typedef struct packed {
      logic        op;
      logic        is_write;
      logic        scrub;
      logic        resilver;
      logic [63:0] offset;
      logic [7:0]  dead_mask;
      logic [7:0]  stale_mask;
      logic [2:0]  child;
      logic [1:0]  child_error;
   } item_type;

   typedef struct packed {
      logic [3:0] child_count;
      logic       replacing_mode;
      logic [5:0] offset_shift;
      logic       repair_allowed;
   } cfg_type;

   typedef struct packed {
      logic     strobe;
      kind_type kind;
      logic [2:0] target;
      logic [2:0] status;
      logic [3:0] error_count;
      logic       last;
   } rsp_type;

   function automatic logic [3:0] copies(input logic [3:0] cnt);
      logic [3:0] n;
      n = cnt;
      if (n == 4'd0) n = 4'd1;
      if (n > COPY_MAX) n = COPY_MAX;
      return n;
   endfunction

   function automatic logic [2:0] mod_small(input logic [2:0] p, input logic [3:0] n);
      logic [3:0] r;
      r = {1'b0, p};
      for (int i = 0; i < NUM_COPIES; i++) begin
         if (r >= n) r = r - n;
      end
      return r[2:0];
   endfunction

endpackage

// ===== src/mcsr_queue.sv =====
// Front part: accepts requests into a two-entry queue ahead of the engine.
module mcsr_queue
   import mcsr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item,
   output logic     full
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== src/mcsr_engine.sv =====
// Back part: copy selection, issue, error merge and repair sequencing.
module mcsr_engine
   import mcsr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   output rsp_type  rsp
);

   eng_state_type state_ff, state_in;
   logic [7:0]  tried_ff, tried_in;
   logic [7:0]  skipped_ff, skipped_in;
   logic [2:0]  status_ff [NUM_COPIES];
   logic [2:0]  status_in [NUM_COPIES];
   logic [3:0]  outst_ff, outst_in;
   logic [2:0]  pref_ff, pref_in;
   logic        wr_ff, wr_in, scrub_ff, scrub_in, resil_ff, resil_in;
   logic [7:0]  dead_ff, dead_in, stale_ff, stale_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  cur_ff, cur_in;
   logic [3:0]  rem_ff, rem_in;
   logic [63:0] shv_ff, shv_in;
   logic [5:0]  bitcnt_ff, bitcnt_in;
   logic [3:0]  good_ff, good_in, unexp_ff, unexp_in, nerr_ff, nerr_in;
   logic [2:0]  err_ff, err_in;
   logic        src_ff, src_in;
   rsp_type     rsp_ff, rsp_in;

   logic [3:0] n;
   logic [3:0] mod_t;
   logic [3:0] cur_next;
   logic [2:0] c;
   logic       found;
   logic [2:0] first_free;

   assign n = copies(cfg.child_count);
   assign rsp = rsp_ff;
   assign item_pop = (state_ff == ENG_IDLE) && item_valid;
   assign mod_t = {rem_ff[2:0], shv_ff[63]};
   assign cur_next = ({1'b0, cur_ff} + 4'd1 == n) ? 4'd0 : {1'b0, cur_ff} + 4'd1;
   assign c = idx_ff[2:0];

   always_comb begin
      found = 1'b0;
      first_free = 3'd0;
      for (int i = NUM_COPIES - 1; i >= 0; i--) begin
         if (i < n && !tried_ff[i]) begin
            found = 1'b1;
            first_free = 3'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      tried_in = tried_ff;
      skipped_in = skipped_ff;
      status_in = status_ff;
      outst_in = outst_ff;
      pref_in = pref_ff;
      wr_in = wr_ff;
      scrub_in = scrub_ff;
      resil_in = resil_ff;
      dead_in = dead_ff;
      stale_in = stale_ff;
      idx_in = idx_ff;
      cur_in = cur_ff;
      rem_in = rem_ff;
      shv_in = shv_ff;
      bitcnt_in = bitcnt_ff;
      good_in = good_ff;
      unexp_in = unexp_ff;
      nerr_in = nerr_ff;
      err_in = err_ff;
      src_in = src_ff;
      rsp_in = '0;
      rsp_in.kind = KIND_READ;
      case (state_ff)
         ENG_IDLE: begin
            if (item_valid) begin
               if (!item.op) begin
                  if (outst_ff == 4'd0) begin
                     tried_in = '0;
                     skipped_in = '0;
                     for (int i = 0; i < NUM_COPIES; i++) status_in[i] = ST_OK;
                     wr_in = item.is_write;
                     scrub_in = item.scrub;
                     resil_in = item.resilver;
                     dead_in = item.dead_mask;
                     stale_in = item.stale_mask;
                     if (cfg.replacing_mode) begin
                        pref_in = 3'd0;
                        state_in = ENG_DISPATCH;
                     end else begin
                        shv_in = item.offset >> cfg.offset_shift;
                        rem_in = 4'd0;
                        bitcnt_in = 6'd0;
                        state_in = ENG_MOD;
                     end
                  end
               end else if (outst_ff != 4'd0 && {1'b0, item.child} < n) begin
                  status_in[item.child] = {1'b0, item.child_error};
                  tried_in[item.child] = 1'b1;
                  skipped_in[item.child] = 1'b0;
                  outst_in = outst_ff - 4'd1;
                  if (outst_ff == 4'd1) begin
                     idx_in = 4'd0;
                     good_in = 4'd0;
                     unexp_in = 4'd0;
                     nerr_in = 4'd0;
                     err_in = ST_OK;
                     state_in = ENG_FIN_SCAN;
                  end
               end
            end
         end
         ENG_MOD: begin
            rem_in = (mod_t >= n) ? mod_t - n : mod_t;
            shv_in = {shv_ff[62:0], 1'b0};
            bitcnt_in = bitcnt_ff + 6'd1;
            if (bitcnt_ff == 6'd63) begin
               pref_in = rem_in[2:0];
               state_in = ENG_DISPATCH;
            end
         end
         ENG_DISPATCH: begin
            idx_in = 4'd0;
            if (wr_ff) begin
               if (resil_ff && cfg.replacing_mode && !stale_ff[0]) begin
                  rsp_in.strobe = 1'b1;
                  rsp_in.kind = KIND_WRITE;
                  rsp_in.target = 3'(n - 4'd1);
                  rsp_in.last = 1'b1;
                  outst_in = 4'd1;
                  state_in = ENG_IDLE;
               end else begin
                  state_in = ENG_ISSUE_ALL;
               end
            end else if (scrub_ff && !cfg.replacing_mode) begin
               state_in = ENG_ISSUE_ALL;
            end else begin
               cur_in = mod_small(pref_ff, n);
               src_in = 1'b0;
               state_in = ENG_SEL1;
            end
         end
         ENG_ISSUE_ALL: begin
            rsp_in.strobe = 1'b1;
            rsp_in.kind = wr_ff ? KIND_WRITE : KIND_READ;
            rsp_in.target = c;
            rsp_in.last = (idx_ff + 4'd1 == n);
            idx_in = idx_ff + 4'd1;
            if (idx_ff + 4'd1 == n) begin
               outst_in = n;
               state_in = ENG_IDLE;
            end
         end
         ENG_SEL1: begin
            if (idx_ff == n) begin
               state_in = ENG_SEL2;
            end else begin
               idx_in = idx_ff + 4'd1;
               cur_in = cur_next[2:0];
               if (!(tried_ff[cur_ff] || skipped_ff[cur_ff])) begin
                  if (dead_ff[cur_ff]) begin
                     status_in[cur_ff] = ST_NODEV;
                     tried_in[cur_ff] = 1'b1;
                     skipped_in[cur_ff] = 1'b1;
                  end else if (!stale_ff[cur_ff]) begin
                     rsp_in.strobe = 1'b1;
                     rsp_in.kind = KIND_READ;
                     rsp_in.target = cur_ff;
                     rsp_in.last = 1'b1;
                     outst_in = 4'd1;
                     state_in = ENG_IDLE;
                  end else begin
                     status_in[cur_ff] = ST_STALE;
                     skipped_in[cur_ff] = 1'b1;
                  end
               end
            end
         end
         ENG_SEL2: begin
            if (found) begin
               rsp_in.strobe = 1'b1;
               rsp_in.kind = KIND_READ;
               rsp_in.target = first_free;
               rsp_in.last = 1'b1;
               outst_in = 4'd1;
               state_in = ENG_IDLE;
            end else if (!src_ff) begin
               idx_in = 4'd0;
               good_in = 4'd0;
               unexp_in = 4'd0;
               nerr_in = 4'd0;
               err_in = ST_OK;
               state_in = ENG_FIN_SCAN;
            end else begin
               rsp_in.strobe = 1'b1;
               rsp_in.kind = KIND_COMPLETE;
               rsp_in.status = err_ff;
               rsp_in.error_count = nerr_ff;
               rsp_in.last = 1'b1;
               state_in = ENG_IDLE;
            end
         end
         ENG_FIN_SCAN: begin
            if (idx_ff == n) begin
               state_in = ENG_FIN_DECIDE;
            end else begin
               idx_in = idx_ff + 4'd1;
               if (tried_ff[c] && status_ff[c] == ST_OK) begin
                  good_in = good_ff + 4'd1;
               end else if (status_ff[c] != ST_OK) begin
                  if (err_ff != ST_IO) err_in = status_ff[c];
                  if (!skipped_ff[c]) unexp_in = unexp_ff + 4'd1;
                  nerr_in = nerr_ff + 4'd1;
               end
            end
         end
         ENG_FIN_DECIDE: begin
            idx_in = 4'd0;
            if (wr_ff) begin
               rsp_in.strobe = 1'b1;
               rsp_in.kind = KIND_COMPLETE;
               rsp_in.status = (good_ff != 4'd0) ? ST_OK : err_ff;
               rsp_in.error_count = nerr_ff;
               rsp_in.last = 1'b1;
               state_in = ENG_IDLE;
            end else if (good_ff == 4'd0) begin
               cur_in = mod_small(pref_ff, n);
               src_in = 1'b1;
               state_in = ENG_SEL1;
            end else if (cfg.repair_allowed && (unexp_ff != 4'd0 || resil_ff ||
                         (scrub_ff && cfg.replacing_mode))) begin
               state_in = ENG_REPAIR;
            end else begin
               rsp_in.strobe = 1'b1;
               rsp_in.kind = KIND_COMPLETE;
               rsp_in.status = ST_OK;
               rsp_in.error_count = nerr_ff;
               rsp_in.last = 1'b1;
               state_in = ENG_IDLE;
            end
         end
         ENG_REPAIR: begin
            if (idx_ff == n) begin
               rsp_in.strobe = 1'b1;
               rsp_in.kind = KIND_COMPLETE;
               rsp_in.status = ST_OK;
               rsp_in.error_count = nerr_ff;
               rsp_in.last = 1'b1;
               state_in = ENG_IDLE;
            end else begin
               idx_in = idx_ff + 4'd1;
               rsp_in.kind = KIND_REPAIR;
               rsp_in.target = c;
               if (status_ff[c] != ST_OK) begin
                  rsp_in.strobe = 1'b1;
               end else if (!tried_ff[c] && (scrub_ff || stale_ff[c])) begin
                  status_in[c] = ST_STALE;
                  rsp_in.strobe = 1'b1;
               end
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         tried_ff <= '0;
         skipped_ff <= '0;
         for (int i = 0; i < NUM_COPIES; i++) status_ff[i] <= ST_OK;
         outst_ff <= 4'd0;
         pref_ff <= 3'd0;
         wr_ff <= 1'b0;
         scrub_ff <= 1'b0;
         resil_ff <= 1'b0;
         dead_ff <= '0;
         stale_ff <= '0;
         src_ff <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         tried_ff <= tried_in;
         skipped_ff <= skipped_in;
         status_ff <= status_in;
         outst_ff <= outst_in;
         pref_ff <= pref_in;
         wr_ff <= wr_in;
         scrub_ff <= scrub_in;
         resil_ff <= resil_in;
         dead_ff <= dead_in;
         stale_ff <= stale_in;
         src_ff <= src_in;
         rsp_ff.strobe <= rsp_in.strobe;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      shv_ff <= shv_in;
      bitcnt_ff <= bitcnt_in;
      good_ff <= good_in;
      unexp_ff <= unexp_in;
      nerr_ff <= nerr_in;
      err_ff <= err_in;
      rsp_ff.kind <= rsp_in.kind;
      rsp_ff.target <= rsp_in.target;
      rsp_ff.status <= rsp_in.status;
      rsp_ff.error_count <= rsp_in.error_count;
      rsp_ff.last <= rsp_in.last;
   end

endmodule

// ===== src/mirror_copy_select_and_repair.sv =====
// Mirrored request dispatcher: top level with configuration registers.
// A request is taken when start is high and busy is low; requests wait in a
// two-entry queue while the engine works, and busy rises only when it is full.
// The engine handles one request at a time and emits at most one result per
// cycle on rsp_strobe; results cannot be held off. A start without a
// replacing arrangement first runs the bit-serial offset modulo, then issues
// its accesses; copy selection, error merge and repair each scan one copy per
// cycle and then finish with a closing step; each result is registered and
// shows in the cycle after the engine state that makes it.
module mirror_copy_select_and_repair
   import mcsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic        req_is_write,
   input  logic        req_scrub,
   input  logic        req_resilver,
   input  logic [63:0] req_offset,
   input  logic [7:0]  req_dead_mask,
   input  logic [7:0]  req_stale_mask,
   input  logic [2:0]  req_child,
   input  logic [1:0]  req_child_error,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_target,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_error_count,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_write_data
);

   cfg_type  cfg_ff, cfg_in;
   item_type push_item, head_item;
   logic     head_valid, pop, full;
   rsp_type  rsp;

   assign push_item = '{op: req_op, is_write: req_is_write, scrub: req_scrub,
                        resilver: req_resilver, offset: req_offset,
                        dead_mask: req_dead_mask, stale_mask: req_stale_mask,
                        child: req_child, child_error: req_child_error};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_CHILD_COUNT: cfg_in.child_count = csr_write_data[3:0];
            REG_REPLACING: cfg_in.replacing_mode = csr_write_data[0];
            REG_OFFSET_SHIFT: cfg_in.offset_shift = csr_write_data;
            REG_REPAIR_ALLOWED: cfg_in.repair_allowed = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{child_count: 4'd2, replacing_mode: 1'b0,
                     offset_shift: 6'd21, repair_allowed: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mcsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (start),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (full)
   );

   mcsr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (pop),
      .rsp        (rsp)
   );

   assign busy = full;
   assign rsp_strobe = rsp.strobe;
   assign rsp_kind = rsp.kind;
   assign rsp_target = rsp.target;
   assign rsp_status = rsp.status;
   assign rsp_error_count = rsp.error_count;
   assign rsp_last = rsp.last;

   a_complete_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == KIND_COMPLETE |-> rsp_last)
      else $error("complete without last");

   a_repair_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == KIND_REPAIR |-> !rsp_last)
      else $error("repair marked last");

   a_issue_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != KIND_COMPLETE |-> rsp_status == ST_OK
      && rsp_error_count == 4'd0)
      else $error("issue carries status");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity after reset");

endmodule
